// File: hw/rtl/mtk_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multitap keypad encoder package
// Shared symbol codes, character codes, the queue entry type and the letter
// tables of the phone keypad.
// ----------------------------------------------------------------------------
package mtk_pkg;

	localparam int unsigned QUEUE_DEPTH_DEF = 4;

	localparam logic [3:0] SYM_STAR  = 4'd10;
	localparam logic [3:0] SYM_HASH  = 4'd11;
	localparam logic [3:0] SYM_PAUSE = 4'd12;
	localparam logic [3:0] NO_KEY    = 4'd15;
	localparam logic [3:0] KEY_SPACE = 4'd0;
	localparam logic [3:0] KEY_MARK  = 4'd1;

	localparam logic [7:0] CHR_SPACE  = 8'h20;
	localparam logic [7:0] CHR_BANG   = 8'h21;
	localparam logic [7:0] CHR_COMMA  = 8'h2C;
	localparam logic [7:0] CHR_STOP   = 8'h2E;
	localparam logic [7:0] CHR_DIG_LO = 8'h30;
	localparam logic [7:0] CHR_DIG_HI = 8'h39;
	localparam logic [7:0] CHR_QUERY  = 8'h3F;
	localparam logic [7:0] CHR_UC_LO  = 8'h41;
	localparam logic [7:0] CHR_UC_HI  = 8'h5A;
	localparam logic [7:0] CHR_LC_LO  = 8'h61;
	localparam logic [7:0] CHR_LC_HI  = 8'h7A;

	// One queue word: an optional leading hash or pause, then the body.
	typedef struct packed {
		logic       pre_en;
		logic [3:0] pre_sym;
		logic       star;
		logic [3:0] key;
		logic [2:0] cnt;
	} mtk_desc_t;

	function automatic logic [3:0] letter_key(input logic [4:0] idx);
		logic [3:0] k;
		k = 4'd0;
		case (idx) inside
			[5'd0:5'd2]:   k = 4'd2;
			[5'd3:5'd5]:   k = 4'd3;
			[5'd6:5'd8]:   k = 4'd4;
			[5'd9:5'd11]:  k = 4'd5;
			[5'd12:5'd14]: k = 4'd6;
			[5'd15:5'd18]: k = 4'd7;
			[5'd19:5'd21]: k = 4'd8;
			[5'd22:5'd25]: k = 4'd9;
			default:       k = 4'd0;
		endcase
		return k;
	endfunction

	function automatic logic [2:0] letter_presses(input logic [4:0] idx);
		logic [2:0] p;
		p = 3'd0;
		case (idx) inside
			5'd0, 5'd3, 5'd6, 5'd9, 5'd12, 5'd15, 5'd19, 5'd22:  p = 3'd1;
			5'd1, 5'd4, 5'd7, 5'd10, 5'd13, 5'd16, 5'd20, 5'd23: p = 3'd2;
			5'd2, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd21, 5'd24: p = 3'd3;
			5'd18, 5'd25:                                        p = 3'd4;
			default:                                             p = 3'd0;
		endcase
		return p;
	endfunction

endpackage
`default_nettype wire

// File: hw/rtl/mtk_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multitap keypad encoder front end
// Accepts characters, classifies them, tracks case and last key, and writes
// one queue word for every character that yields symbols.
// ----------------------------------------------------------------------------
module mtk_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [7:0]        character,
	input  wire logic              first_of_message,
	input  wire logic              q_full,
	output mtk_pkg::mtk_desc_t     push_desc,
	output logic                   push
);
	import mtk_pkg::*;

	logic       prev_upper_q;
	logic [3:0] last_key_q;
	logic       accept;
	logic       prev_eff;
	logic [3:0] last_eff;
	logic       upper;
	logic       star;
	logic [3:0] key;
	logic [2:0] cnt;
	logic [3:0] first_code;
	logic       hash;
	logic       pause;
	logic [3:0] new_last;
	logic [4:0] idx;

	assign accept   = in_valid && !q_full;
	assign prev_eff = first_of_message ? 1'b0 : prev_upper_q;
	assign last_eff = first_of_message ? NO_KEY : last_key_q;
	assign idx      = character[4:0] - 5'd1;

	always_comb begin
		upper = 1'b0;
		star  = 1'b0;
		key   = 4'd0;
		cnt   = 3'd0;
		case (character) inside
			[CHR_DIG_LO:CHR_DIG_HI]: begin
				star = 1'b1;
				key  = character[3:0];
				cnt  = 3'd2;
			end
			[CHR_UC_LO:CHR_UC_HI]: begin
				upper = 1'b1;
				key   = letter_key(idx);
				cnt   = letter_presses(idx);
			end
			[CHR_LC_LO:CHR_LC_HI]: begin
				key = letter_key(idx);
				cnt = letter_presses(idx);
			end
			CHR_SPACE: begin
				key = KEY_SPACE;
				cnt = 3'd1;
			end
			CHR_STOP: begin
				key = KEY_MARK;
				cnt = 3'd1;
			end
			CHR_COMMA: begin
				key = KEY_MARK;
				cnt = 3'd2;
			end
			CHR_BANG: begin
				key = KEY_MARK;
				cnt = 3'd3;
			end
			CHR_QUERY: begin
				key = KEY_MARK;
				cnt = 3'd4;
			end
			default: begin
				cnt = 3'd0;
			end
		endcase
	end

	assign first_code = star ? SYM_STAR : key;
	assign hash       = upper != prev_eff;
	assign pause      = !hash && (cnt != 3'd0) && (first_code == last_eff);
	assign new_last   = (cnt != 3'd0) ? key : (hash ? SYM_HASH : last_eff);

	assign push              = accept && (hash || (cnt != 3'd0));
	assign push_desc.pre_en  = hash || pause;
	assign push_desc.pre_sym = hash ? SYM_HASH : SYM_PAUSE;
	assign push_desc.star    = star;
	assign push_desc.key     = key;
	assign push_desc.cnt     = cnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_upper_q <= 1'b0;
			last_key_q   <= NO_KEY;
		end else if (accept) begin
			prev_upper_q <= upper;
			last_key_q   <= new_last;
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mtk_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multitap keypad encoder queue
// A short first-in first-out store of words between the front end and the
// symbol sequencer.
// ----------------------------------------------------------------------------
module mtk_queue #(
	parameter int unsigned DEPTH = mtk_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	input  wire mtk_pkg::mtk_desc_t       push_desc,
	input  wire logic                     pop,
	output mtk_pkg::mtk_desc_t            head_desc,
	output logic                          full,
	output logic                          empty,
	output logic [$clog2(DEPTH+1)-1:0]    count
);
	import mtk_pkg::*;

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	mtk_desc_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = count_q == CNT_W'(DEPTH);
	assign empty     = count_q == '0;
	assign count     = count_q;
	assign do_push   = push && !full;
	assign do_pop    = pop && !empty;
	assign head_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/mtk_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multitap keypad encoder symbol sequencer
// Expands the queue word at the head into key symbols, one per cycle while
// the output is not stalled, into a registered output stage.
// ----------------------------------------------------------------------------
module mtk_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire mtk_pkg::mtk_desc_t head_desc,
	input  wire logic           empty,
	output logic                pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [3:0]          key_symbol,
	output logic                last_of_run
);
	import mtk_pkg::*;

	logic [2:0] step_q;
	logic       out_valid_q;
	logic [3:0] sym_q;
	logic       last_q;
	logic       advance;
	logic [2:0] total;
	logic [2:0] body_idx;
	logic       is_last;
	logic [3:0] sym;

	assign advance  = !empty && (!out_valid_q || !out_stall);
	assign total    = {2'b00, head_desc.pre_en} + head_desc.cnt;
	assign body_idx = step_q - {2'b00, head_desc.pre_en};
	assign is_last  = step_q == (total - 3'd1);
	assign pop      = advance && is_last;

	always_comb begin
		if (head_desc.pre_en && (step_q == 3'd0)) begin
			sym = head_desc.pre_sym;
		end else if (head_desc.star && (body_idx == 3'd0)) begin
			sym = SYM_STAR;
		end else begin
			sym = head_desc.key;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				step_q      <= is_last ? 3'd0 : step_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			sym_q  <= sym;
			last_q <= is_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign key_symbol  = sym_q;
	assign last_of_run = last_q;

endmodule
`default_nettype wire

// File: hw/rtl/multitap_keypad_encoder_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multitap keypad encoder
// Turns text characters into phone keypad multitap key symbols, with case
// toggles and pause separators.
// ----------------------------------------------------------------------------
// The first symbol of a character is written to the queue and then to the
// output register. Throughput: one symbol per cycle while the output is not
// stalled; a character yields one to five symbols, all through the single
// output register; characters without symbols write no queue word.
// Reset clears case and last key state, the queue and the output stage.
module multitap_keypad_encoder_core #(
	parameter int unsigned QUEUE_DEPTH = mtk_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] character,
	input  wire logic       first_of_message,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [3:0]      key_symbol,
	output logic            last_of_run
);
	import mtk_pkg::*;

	mtk_desc_t                      push_desc;
	mtk_desc_t                      head_desc;
	logic                           push;
	logic                           pop;
	logic                           full;
	logic                           empty;
	logic [$clog2(QUEUE_DEPTH+1)-1:0] q_count;

	assign in_stall = full;

	mtk_front u_front (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.character        (character),
		.first_of_message (first_of_message),
		.q_full           (full),
		.push_desc        (push_desc),
		.push             (push)
	);

	mtk_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head_desc (head_desc),
		.full      (full),
		.empty     (empty),
		.count     (q_count)
	);

	mtk_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_desc   (head_desc),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.key_symbol  (key_symbol),
		.last_of_run (last_of_run)
	);

	a_sym_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> key_symbol <= SYM_PAUSE)
		else $error("key symbol out of range");

	a_prefix_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (key_symbol == SYM_PAUSE || key_symbol == SYM_STAR) |-> !last_of_run)
		else $error("pause or star closed a run");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QUEUE_DEPTH+1))'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue popped while empty");

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multitap keypad encoder testbench
// Sends text characters to the encoder and checks every key symbol word
// that comes back. The checks use an independent model of the keypad code,
// the case toggle and the pause separator, or the symbols given in a
// directed row. A short table of directed characters comes first, followed
// by 250 random ones. Both sides of the block are held off in random bursts.
// ----------------------------------------------------------------------------
module testbench;
	import mtk_pkg::*;

	typedef struct packed {
		logic [3:0] sym;
		logic       last;
	} key_word_t;

	typedef struct packed {
		logic [7:0]      ch;
		logic            first;
		logic            typed;
		logic [2:0]      n;
		logic [0:4][3:0] syms;
	} char_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] character;
	logic       first_of_message;
	logic       out_valid;
	logic       out_stall;
	logic [3:0] key_symbol;
	logic       last_of_run;

	key_word_t  symbols_due[$];
	logic       case_upper;
	logic [3:0] key_last;
	int         mismatches;
	int         in_gap_odds;
	int         out_stall_odds;

	multitap_keypad_encoder_core dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.character        (character),
		.first_of_message (first_of_message),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.key_symbol       (key_symbol),
		.last_of_run      (last_of_run)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 100) begin
			$display("MISMATCH at %0t: %s", $realtime, msg);
		end
	endtask

	// Key symbols for one character; also advances the case and last key state.
	function automatic int encode_char(input logic [7:0] ch, input logic first,
			output logic [0:4][3:0] syms);
		logic       upper;
		logic       star;
		logic [3:0] key;
		logic [3:0] lead;
		int         presses;
		int         idx;
		int         n;
		syms = '0;
		if (first) begin
			case_upper = 1'b0;
			key_last = NO_KEY;
		end
		upper = (ch >= CHR_UC_LO && ch <= CHR_UC_HI);
		star = 1'b0;
		key = KEY_SPACE;
		presses = 0;
		if (ch >= CHR_DIG_LO && ch <= CHR_DIG_HI) begin
			star = 1'b1;
			key = 4'(ch - CHR_DIG_LO);
			presses = 1;
		end else if (upper || (ch >= CHR_LC_LO && ch <= CHR_LC_HI)) begin
			idx = upper ? int'(ch - CHR_UC_LO) : int'(ch - CHR_LC_LO);
			if (idx < 15) begin
				key = 4'(2 + idx / 3);
				presses = idx % 3 + 1;
			end else if (idx < 19) begin
				key = 4'd7;
				presses = idx - 14;
			end else if (idx < 22) begin
				key = 4'd8;
				presses = idx - 18;
			end else begin
				key = 4'd9;
				presses = idx - 21;
			end
		end else if (ch == CHR_SPACE) begin
			presses = 1;
		end else if (ch == CHR_STOP) begin
			key = KEY_MARK;
			presses = 1;
		end else if (ch == CHR_COMMA) begin
			key = KEY_MARK;
			presses = 2;
		end else if (ch == CHR_BANG) begin
			key = KEY_MARK;
			presses = 3;
		end else if (ch == CHR_QUERY) begin
			key = KEY_MARK;
			presses = 4;
		end
		lead = star ? SYM_STAR : key;
		n = 0;
		if (upper != case_upper) begin
			syms[n] = SYM_HASH;
			n = n + 1;
		end else if (presses > 0 && lead == key_last) begin
			syms[n] = SYM_PAUSE;
			n = n + 1;
		end
		if (star) begin
			syms[n] = SYM_STAR;
			n = n + 1;
		end
		for (int i = 0; i < presses; i++) begin
			syms[n] = key;
			n = n + 1;
		end
		case_upper = upper;
		if (n > 0) begin
			key_last = syms[n - 1];
		end
		return n;
	endfunction

	function automatic char_row_t row(input logic [7:0] ch, input logic first,
			input logic typed, input logic [2:0] n,
			input logic [3:0] s0 = 4'd0, input logic [3:0] s1 = 4'd0,
			input logic [3:0] s2 = 4'd0, input logic [3:0] s3 = 4'd0,
			input logic [3:0] s4 = 4'd0);
		char_row_t r;
		r.ch = ch;
		r.first = first;
		r.typed = typed;
		r.n = n;
		r.syms = {s0, s1, s2, s3, s4};
		return r;
	endfunction

	task automatic send_char(input char_row_t r);
		logic [0:4][3:0] syms;
		int              n;
		@(negedge clk);
		if (in_gap_odds != 0 && $urandom_range(1, in_gap_odds) == 1) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid = 1'b1;
		character = r.ch;
		first_of_message = r.first;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		n = encode_char(r.ch, r.first, syms);
		if (r.typed) begin
			n = r.n;
			syms = r.syms;
		end
		for (int i = 0; i < n; i++) begin
			symbols_due.push_back('{sym: syms[i], last: (i == n - 1)});
		end
	endtask

	always @(posedge clk) begin
		key_word_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (symbols_due.size() == 0) begin
				note_mismatch($sformatf("unexpected word, symbol %0d", key_symbol));
			end else begin
				due = symbols_due.pop_front();
				if (key_symbol !== due.sym) begin
					note_mismatch($sformatf("key_symbol %0d, expected %0d",
						key_symbol, due.sym));
				end
				if (last_of_run !== due.last) begin
					note_mismatch($sformatf("last_of_run %0b, expected %0b",
						last_of_run, due.last));
				end
			end
		end
	end

	initial begin
		int hold;
		hold = 0;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold == 0 && out_stall_odds != 0 && $urandom_range(1, out_stall_odds) == 1) begin
				hold = $urandom_range(1, 12);
			end
			out_stall = (hold != 0);
			if (hold != 0) begin
				hold--;
			end
		end
	end

	initial begin
		char_row_t  plan[$];
		logic [7:0] ch;
		logic [7:0] prev_ch;
		int         pick;
		arst_n = 1'b0;
		in_valid = 1'b0;
		character = 8'h00;
		first_of_message = 1'b0;
		mismatches = 0;
		in_gap_odds = 0;
		out_stall_odds = 0;
		case_upper = 1'b0;
		key_last = NO_KEY;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;

		plan.push_back(row("a", 1'b1, 1'b1, 3'd1, 4'd2));
		plan.push_back(row("b", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("Z", 1'b0, 1'b1, 3'd5, SYM_HASH, 4'd9, 4'd9, 4'd9, 4'd9));
		plan.push_back(row("A", 1'b0, 1'b0, 3'd0));
		plan.push_back(row(8'h00, 1'b0, 1'b1, 3'd1, SYM_HASH));
		plan.push_back(row(8'hFF, 1'b0, 1'b1, 3'd0));
		plan.push_back(row("0", 1'b0, 1'b1, 3'd2, SYM_STAR, 4'd0));
		plan.push_back(row(" ", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("9", 1'b0, 1'b1, 3'd2, SYM_STAR, 4'd9));
		plan.push_back(row(".", 1'b0, 1'b0, 3'd0));
		plan.push_back(row(",", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("!", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("?", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("z", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("S", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("K", 1'b1, 1'b0, 3'd0));
		plan.push_back(row("#", 1'b0, 1'b0, 3'd0));
		plan.push_back(row(8'h80, 1'b0, 1'b0, 3'd0));
		plan.push_back(row("w", 1'b1, 1'b0, 3'd0));
		plan.push_back(row("x", 1'b0, 1'b0, 3'd0));
		plan.push_back(row(8'h7F, 1'b0, 1'b0, 3'd0));
		plan.push_back(row("s", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("1", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("Y", 1'b0, 1'b0, 3'd0));
		plan.push_back(row("@", 1'b0, 1'b0, 3'd0));

		in_gap_odds = 3;
		out_stall_odds = 3;
		foreach (plan[i]) begin
			send_char(plan[i]);
		end

		prev_ch = "a";
		for (int i = 0; i < 250; i++) begin
			case (i / 50)
				0: begin in_gap_odds = 4; out_stall_odds = 4; end
				1: begin in_gap_odds = 0; out_stall_odds = 0; end
				2: begin in_gap_odds = 2; out_stall_odds = 2; end
				3: begin in_gap_odds = 6; out_stall_odds = 3; end
				default: begin in_gap_odds = 0; out_stall_odds = 0; end
			endcase
			pick = $urandom_range(0, 99);
			if (pick < 40) begin
				ch = 8'("a" + $urandom_range(0, 25));
			end else if (pick < 55) begin
				ch = 8'("A" + $urandom_range(0, 25));
			end else if (pick < 65) begin
				ch = 8'(CHR_DIG_LO + $urandom_range(0, 9));
			end else if (pick < 77) begin
				case ($urandom_range(0, 4))
					0: ch = CHR_SPACE;
					1: ch = CHR_STOP;
					2: ch = CHR_COMMA;
					3: ch = CHR_BANG;
					default: ch = CHR_QUERY;
				endcase
			end else if (pick < 92) begin
				ch = 8'($urandom_range(0, 255));
			end else begin
				ch = prev_ch;
			end
			prev_ch = ch;
			send_char(row(ch, ($urandom_range(0, 15) == 0), 1'b0, 3'd0));
		end

		@(negedge clk);
		in_valid = 1'b0;
		while (symbols_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/mtk_pkg.sv
hw/rtl/mtk_front.sv
hw/rtl/mtk_queue.sv
hw/rtl/mtk_back.sv
hw/rtl/multitap_keypad_encoder_core.sv
verif/testbench.sv
